/* hdl/bet_pkg.sv */
package bet_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] time_point;
        logic signed [31:0] sample_value;
        logic [5:0]         entry_index;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [6:0]         entry_count;
        logic [1:0]         status;
    } t_out_item;

    // request to the divider
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } t_div_rsp;

endpackage

/* hdl/bet_divider.sv */
module bet_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bet_pkg::t_div_req i_req,
    output bet_pkg::t_div_rsp o_rsp
);
    import bet_pkg::*;

    logic [63:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_div;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_trial;
    logic [32:0] w_diff;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem[31:0], r_quo[63]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            if (!w_diff[32]) begin
                r_rem <= w_diff;
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* hdl/breakpoint_envelope_table.sv */
// Channel | Direction | Transfer when     | Payload
// in      | input     | i_valid & o_ready | bet_pkg::t_in_item
// out     | output    | o_valid & i_ready | bet_pkg::t_out_item
// cfg     | input     | i_cfg_we          | i_cfg_data (interp enable)
// One item at a time; o_valid rises once the input item is done: an insert scans,
// then shifts through the memory port; a delete shifts the later entries down; a
// lookup scans, then goes through the multiply and the bit-serial 64/32 divider when
// interpolating. Full insert, bad delete index, empty lookup and the unused command
// go straight to the output.
// Reset clears the count, interp enable goes to 1; the memory is not cleared.
// A waiting result holds o_valid; the next item is taken the cycle after it transfers.
module breakpoint_envelope_table #(
    parameter int DEPTH     = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  bet_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output bet_pkg::t_out_item  o_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data
);
    import bet_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    // binary point cancels in the ratio; kept for format documentation
    localparam int FRACB = FRAC_BITS;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SCAN  = 8'b00000010,
        S_SHIFT = 8'b00000100,
        S_PAIR  = 8'b00001000,
        S_MUL   = 8'b00010000,
        S_DIV   = 8'b00100000,
        S_DONE  = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state             r_state;
    t_in_item           r_item;
    logic [CW-1:0]      r_count;
    logic               r_interp;
    logic [CW-1:0]      r_ptr;
    logic               r_rd_ok;
    logic [CW-1:0]      r_rd_idx;
    logic [CW-1:0]      r_ins_pos;
    t_out_item          r_out;
    logic signed [31:0] r_t0, r_v0, r_t1, r_v1;
    logic [31:0]        r_mag;
    logic [31:0]        r_off;
    logic [31:0]        r_span;
    logic [63:0]        r_prod;
    logic               r_neg;
    logic               r_div_go;
    logic [1:0]         w_status;

    logic [63:0]        mem [DEPTH];
    logic [63:0]        r_rd;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [63:0]        w_wdata;
    logic [AW-1:0]      w_raddr;

    t_div_req           w_req;
    t_div_rsp           w_rsp;

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rd <= mem[w_raddr];
    end

    bet_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    logic signed [31:0] w_rt, w_rv;
    assign w_rt = r_rd[63:32];
    assign w_rv = r_rd[31:0];

    logic [31:0] w_q32;
    assign w_q32 = w_rsp.quotient[31:0];

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_out;

    always_comb begin
        w_status = ST_OK;
        if (i_data.cmd == CMD_INSERT && r_count >= CW'(DEPTH))
            w_status = ST_FULL;
        if (i_data.cmd == CMD_DELETE && CW'(i_data.entry_index) >= r_count)
            w_status = ST_RANGE;
    end

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ptr[AW-1:0];
        w_wdata = r_rd;
        w_raddr = r_ptr[AW-1:0];
        w_req   = '0;
        w_req.dividend = r_prod;
        w_req.divisor  = r_span;
        if (r_state == S_SHIFT) begin
            if (r_item.cmd == CMD_INSERT) begin
                // walking down: write ptr, read one ahead of the next write
                w_raddr = r_ptr[AW-1:0] - (r_rd_ok ? AW'(2) : AW'(1));
                if (r_rd_ok) begin
                    w_we    = 1'b1;
                    w_waddr = r_ptr[AW-1:0];
                    if (r_ptr == r_ins_pos)
                        w_wdata = {r_item.time_point, r_item.sample_value};
                end
            end else begin
                w_raddr = r_ptr[AW-1:0] + (r_rd_ok ? AW'(2) : AW'(1));
                w_we    = r_rd_ok && (r_ptr + CW'(1) < r_count);
                w_waddr = r_ptr[AW-1:0];
            end
        end
        if (r_state == S_DIV && r_div_go) w_req.start = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_interp <= 1'b1;
            r_rd_ok  <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            if (i_cfg_we) r_interp <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    r_rd_ok <= 1'b0;
                    if (i_valid) begin
                        r_item <= i_data;
                        r_ptr  <= (i_data.cmd == CMD_DELETE) ? CW'(i_data.entry_index) : '0;
                        r_out  <= '{out_value: '0, entry_count: 7'(r_count),
                                    status: w_status};
                        case (i_data.cmd)
                            CMD_INSERT: r_state <= (w_status == ST_FULL) ? S_OUT : S_SCAN;
                            CMD_LOOKUP: r_state <= (r_count == '0) ? S_OUT : S_SCAN;
                            CMD_DELETE: r_state <= (w_status == ST_RANGE) ? S_OUT : S_SHIFT;
                            default:    r_state <= S_OUT;
                        endcase
                    end
                end
                S_SCAN: begin
                    // r_rd holds entry r_rd_idx when r_rd_ok
                    r_rd_idx <= r_ptr;
                    if (r_item.cmd == CMD_INSERT) begin
                        if (r_rd_ok && (w_rt > r_item.time_point)) begin
                            r_ins_pos <= r_rd_idx;
                            r_ptr     <= r_count;
                            r_rd_ok   <= 1'b0;
                            r_state   <= S_SHIFT;
                        end else if (r_rd_ok == 1'b0 && r_ptr > r_count) begin
                            r_ins_pos <= r_count;
                            r_ptr     <= r_count;
                            r_rd_ok   <= 1'b0;
                            r_state   <= S_SHIFT;
                        end else begin
                            r_rd_ok <= (r_ptr < r_count);
                            r_ptr   <= r_ptr + CW'(1);
                        end
                    end else begin
                        r_rd_ok <= (r_ptr < r_count);
                        r_ptr   <= r_ptr + CW'(1);
                        if (r_rd_ok) begin
                            if (r_rd_idx == '0) begin
                                r_t0 <= w_rt;
                                r_v0 <= w_rv;
                                if (r_count == CW'(1) || r_item.time_point <= w_rt) begin
                                    r_out.out_value <= w_rv;
                                    r_state <= S_OUT;
                                end
                            end else if (w_rt > r_item.time_point) begin
                                r_t1 <= w_rt;
                                r_v1 <= w_rv;
                                if (!r_interp) begin
                                    r_out.out_value <= r_v0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_PAIR;
                                end
                            end else begin
                                r_t0 <= w_rt;
                                r_v0 <= w_rv;
                                if (r_rd_idx == r_count - CW'(1)) begin
                                    r_out.out_value <= w_rv;
                                    r_state <= S_OUT;
                                end
                            end
                        end
                    end
                end
                S_SHIFT: begin
                    if (r_item.cmd == CMD_INSERT) begin
                        r_rd_ok <= 1'b1;
                        if (r_rd_ok) begin
                            if (r_ptr == r_ins_pos) begin
                                r_count <= r_count + CW'(1);
                                r_out.entry_count <= 7'(r_count + CW'(1));
                                r_state <= S_OUT;
                            end
                            r_ptr <= r_ptr - CW'(1);
                        end
                    end else begin
                        if (r_ptr + CW'(1) >= r_count) begin
                            r_count <= r_count - CW'(1);
                            r_out.entry_count <= 7'(r_count - CW'(1));
                            r_state <= S_OUT;
                        end else begin
                            r_rd_ok <= 1'b1;
                            if (r_rd_ok) r_ptr <= r_ptr + CW'(1);
                        end
                    end
                end
                S_PAIR: begin
                    if (r_t1 <= r_t0) begin
                        r_out.out_value <= r_v0;
                        r_state <= S_OUT;
                    end else begin
                        r_neg  <= (r_v1 < r_v0);
                        r_mag  <= (r_v1 < r_v0) ? 32'(34'(r_v0) - 34'(r_v1))
                                                : 32'(34'(r_v1) - 34'(r_v0));
                        r_off  <= 32'(34'(r_item.time_point) - 34'(r_t0));
                        r_span <= 32'(34'(r_t1) - 34'(r_t0));
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // product lands at this edge; start the divider next cycle
                    r_div_go <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    r_div_go <= 1'b0;
                    if (w_rsp.done) r_state <= S_DONE;
                end
                S_DONE: begin
                    r_out.out_value <= r_neg ? r_v0 - $signed(w_q32) : r_v0 + $signed(w_q32);
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // magnitudes fit in 32 bits since spans and offsets stay below 2^32
    always_ff @(posedge i_clk) begin
        r_prod <= r_mag * r_off;
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready while result pending");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("count over depth");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("result dropped");
    a_frac: assert property (@(posedge i_clk) FRACB >= 0) else $error("bad frac");
`endif

endmodule
